@@ rtl/deadline_frame_admission_scheduler_core_macros.svh @@
// assertion helpers
`ifndef DEADLINE_FRAME_ADMISSION_SCHEDULER_CORE_MACROS_SVH
`define DEADLINE_FRAME_ADMISSION_SCHEDULER_CORE_MACROS_SVH

// clocked assertion, disabled while reset is low
`define DFAS_ASSERT_AT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// same on the block clock and reset
`define DFAS_ASSERT(label, prop, msg) \
  `DFAS_ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/dfas_pkg.sv @@
package dfas_pkg;

  typedef enum logic [1:0] {
    OP_SUBMIT   = 2'd0,
    OP_CHECK    = 2'd1,
    OP_START    = 2'd2,
    OP_COMPLETE = 2'd3
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_UPD  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [3:0]         frame_idx;
    logic [2:0]         stage;
    logic signed [47:0] pts;
    logic [52:0]        now_us;
    logic               success;
  } item_t;

  typedef struct packed {
    logic        status;
    logic [3:0]  slot;
    logic        proceed;
    logic [34:0] needed_us;
    logic [31:0] stage_estimate;
    logic [31:0] stage_worst;
    logic [31:0] processed_count;
    logic [31:0] dropped_count;
  } result_t;

  typedef struct packed {
    op_e   op;
    logic  fid_ok;
    logic  st_ok;
    item_t item;
  } cmd_t;

  typedef struct packed {
    logic take;
    logic busy;
  } back_stat_t;

  localparam logic [31:0] ZERO_EST_FILL = 32'd10000;
  localparam logic [31:0] EST_RESET     = 32'd8000;
  localparam logic [31:0] WORST_RESET   = 32'd10000;
  localparam logic [1:0]  PH_PENDING    = 2'd0;
  localparam logic [1:0]  PH_PROCESSING = 2'd1;
  localparam logic [1:0]  PH_COMPLETED  = 2'd2;
  localparam logic [1:0]  PH_FAILED     = 2'd3;

endpackage

@@ rtl/deadline_frame_admission_scheduler_core.sv @@
// Frame slot table with deadline admission and per-stage latency windows. Requests
// enter a two-entry queue and are executed one at a time; a submit, check or start
// goes from the queue through the execute and done states to its result, as does a
// complete that does not land on a recalculation point. A complete that does
// rescans its stage's sample window through the single read port of the ring
// memory, one sample a cycle, and then passes through the update state to done. A
// finished result waits in the output register until popped; the next request is
// executed meanwhile and holds only when its own result is ready. The ring needs
// no clearing after reset, so requests are taken straight away. The reference
// time register sits at byte address 0 of the 64-bit config port.
`include "deadline_frame_admission_scheduler_core_macros.svh"
module deadline_frame_admission_scheduler_core #(
  parameter int SLOT_COUNT      = 16,
  parameter int STAGE_COUNT     = 5,
  parameter int WINDOW_DEPTH    = 1000,
  parameter int RECALC_INTERVAL = 100
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  dfas_pkg::item_t   item_i,
  output logic              empty,
  input  logic              pop,
  output dfas_pkg::result_t result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  localparam logic REG_REF_TIME = 1'b0;

  logic [52:0]          ref_time_q;
  logic                 cmd_valid;
  dfas_pkg::cmd_t       cmd;
  dfas_pkg::back_stat_t stat;
  logic                 res_valid;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_REF_TIME) ? {11'd0, ref_time_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_time_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[3] == REG_REF_TIME)) begin
      ref_time_q <= pwdata[52:0];
    end
  end

  dfas_front #(
    .SLOT_COUNT (SLOT_COUNT),
    .STAGE_COUNT(STAGE_COUNT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .item_i     (item_i),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .take_i     (stat.take)
  );

  dfas_back #(
    .SLOT_COUNT     (SLOT_COUNT),
    .STAGE_COUNT    (STAGE_COUNT),
    .WINDOW_DEPTH   (WINDOW_DEPTH),
    .RECALC_INTERVAL(RECALC_INTERVAL)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ref_time_i (ref_time_q),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .res_valid_o(res_valid),
    .res_o      (result_o),
    .pop_i      (pop)
  );

  assign empty = !res_valid;

  `DFAS_ASSERT(a_take_has_head, stat.take |-> cmd_valid, "request taken from empty queue")
  `DFAS_ASSERT(a_result_after_work, $fell(empty) |-> $past(stat.busy), "result without work")
  `DFAS_ASSERT(a_full_has_head, full |-> cmd_valid, "queue full with no head entry")

endmodule

@@ rtl/dfas_ram.sv @@
module dfas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 5000,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/dfas_front.sv @@
module dfas_front #(
  parameter int SLOT_COUNT  = 16,
  parameter int STAGE_COUNT = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  dfas_pkg::item_t      item_i,
  output logic                 cmd_valid_o,
  output dfas_pkg::cmd_t       cmd_o,
  input  logic                 take_i
);

  dfas_pkg::cmd_t q_mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  dfas_pkg::cmd_t cmd_in;
  logic           do_push, do_take;

  always_comb begin
    cmd_in.op     = dfas_pkg::op_e'(item_i.mode);
    cmd_in.fid_ok = ({1'b0, item_i.frame_idx} < 5'(SLOT_COUNT)) || (SLOT_COUNT > 16);
    cmd_in.st_ok  = {1'b0, item_i.stage} < 4'(STAGE_COUNT);
    cmd_in.item   = item_i;
  end

  assign full_o      = cnt_q == 2'd2;
  assign do_push     = push_i && !full_o;
  assign do_take     = take_i && (cnt_q != 2'd0);
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_take) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_take);
    end
  end

endmodule

@@ rtl/dfas_back.sv @@
module dfas_back #(
  parameter int SLOT_COUNT      = 16,
  parameter int STAGE_COUNT     = 5,
  parameter int WINDOW_DEPTH    = 1000,
  parameter int RECALC_INTERVAL = 100
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [52:0]          ref_time_i,
  input  logic                 cmd_valid_i,
  input  dfas_pkg::cmd_t       cmd_i,
  output dfas_pkg::back_stat_t stat_o,
  output logic                 res_valid_o,
  output dfas_pkg::result_t    res_o,
  input  logic                 pop_i
);

  localparam int SLOT_AW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int STG_AW    = $clog2(STAGE_COUNT);
  localparam int POS_W     = $clog2(WINDOW_DEPTH);
  localparam int FILL_W    = $clog2(WINDOW_DEPTH + 1);
  localparam int RC_W      = (RECALC_INTERVAL > 1) ? $clog2(RECALC_INTERVAL) : 1;
  localparam int RAM_DEPTH = STAGE_COUNT * WINDOW_DEPTH;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam int TOP_K     = (WINDOW_DEPTH + 999) / 1000;
  localparam int TOP_W     = (TOP_K > 1) ? $clog2(TOP_K) : 1;
  localparam bit SAT_TRIG  = (WINDOW_DEPTH % RECALC_INTERVAL) == 0;

  dfas_pkg::state_e   state_q;
  dfas_pkg::cmd_t     cmd_q;
  logic [1:0]         phase_q    [SLOT_COUNT];
  logic signed [54:0] deadline_q [SLOT_COUNT];
  logic [52:0]        start_q    [SLOT_COUNT];
  logic [POS_W-1:0]   pos_q      [STAGE_COUNT];
  logic [FILL_W-1:0]  fill_q     [STAGE_COUNT];
  logic [RC_W-1:0]    rc_q       [STAGE_COUNT];
  logic [31:0]        est_q      [STAGE_COUNT];
  logic [31:0]        worst_q    [STAGE_COUNT];
  logic [31:0]        done_cnt_q, drop_cnt_q;
  logic               status_q, proceed_q;
  logic [3:0]         slot_q;
  logic [34:0]        needed_q;
  logic [RAM_AW-1:0]  base_q;
  logic [FILL_W-1:0]  n_q, scan_q;
  logic               rd_vld_q;
  logic [31:0]        top_q      [TOP_K];
  dfas_pkg::result_t  res_q;
  logic               res_vld_q;

  logic [SLOT_AW-1:0] fidx, found_idx;
  logic [STG_AW-1:0]  sidx;
  logic               found;
  logic [3:0]         slot_d;
  logic [34:0]        needed;
  logic signed [54:0] deadline_new;
  logic signed [55:0] left;
  logic               proceed;
  logic [53:0]        diff;
  logic [31:0]        dur;
  logic [RC_W-1:0]    rc_next;
  logic               fill_sat, trig;
  logic [FILL_W-1:0]  fill_new;
  logic [POS_W-1:0]   pos_next;
  logic [RAM_AW-1:0]  base;
  logic [TOP_W-1:0]   rank;
  logic [31:0]        prev       [TOP_K];
  logic [31:0]        top_new    [TOP_K];
  logic               take, cpl_ok, re, we, res_load;
  logic [31:0]        rdata;

  always_comb begin
    fidx = SLOT_AW'(cmd_q.item.frame_idx);
    sidx = STG_AW'(cmd_q.item.stage);
    found = 1'b0;
    found_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (phase_q[i] != dfas_pkg::PH_PROCESSING) begin
        found = 1'b1;
        found_idx = SLOT_AW'(i);
      end
    end
    if (cmd_q.op != dfas_pkg::OP_SUBMIT) slot_d = cmd_q.item.frame_idx;
    else if (found) slot_d = 4'(found_idx);
    else slot_d = 4'd0;
    needed = '0;
    for (int s = 0; s < STAGE_COUNT; s++) begin
      if (s >= int'(cmd_q.item.stage)) begin
        needed = needed + 35'((est_q[s] == 32'd0) ? dfas_pkg::ZERO_EST_FILL : est_q[s]);
      end
    end
    deadline_new = $signed({2'b00, ref_time_i}) + 55'($signed(cmd_q.item.pts));
    left = $signed({deadline_q[fidx][54], deadline_q[fidx]})
         - $signed({3'b000, cmd_q.item.now_us});
    proceed = cmd_q.fid_ok && !(left < $signed({21'd0, needed}));
    diff = {1'b0, cmd_q.item.now_us} - {1'b0, start_q[fidx]};
    if (diff[53]) dur = '0;
    else if (|diff[52:32]) dur = '1;
    else dur = diff[31:0];
    rc_next = (rc_q[sidx] == RC_W'(RECALC_INTERVAL - 1)) ? '0 : rc_q[sidx] + 1'b1;
    fill_sat = fill_q[sidx] == FILL_W'(WINDOW_DEPTH);
    trig = fill_sat ? SAT_TRIG : (rc_next == '0);
    fill_new = fill_sat ? fill_q[sidx] : fill_q[sidx] + 1'b1;
    pos_next = (pos_q[sidx] == POS_W'(WINDOW_DEPTH - 1)) ? '0 : pos_q[sidx] + 1'b1;
    base = RAM_AW'(int'(sidx) * WINDOW_DEPTH);
    rank = '0;
    for (int k = 1; k < TOP_K; k++) begin
      if (n_q > FILL_W'(k * 1000)) rank = rank + 1'b1;
    end
    prev[0] = '1;
    for (int i = 1; i < TOP_K; i++) begin
      prev[i] = top_q[i-1];
    end
    for (int i = 0; i < TOP_K; i++) begin
      if (rdata > top_q[i]) top_new[i] = (rdata > prev[i]) ? prev[i] : rdata;
      else top_new[i] = top_q[i];
    end
  end

  assign take     = (state_q == dfas_pkg::ST_IDLE) && cmd_valid_i;
  assign cpl_ok   = (state_q == dfas_pkg::ST_EXEC) && (cmd_q.op == dfas_pkg::OP_COMPLETE)
                 && cmd_q.fid_ok && cmd_q.st_ok;
  assign we       = cpl_ok;
  assign re       = (state_q == dfas_pkg::ST_SCAN) && (scan_q < n_q);
  assign res_load = (state_q == dfas_pkg::ST_DONE) && (!res_vld_q || pop_i);

  assign stat_o.take = take;
  assign stat_o.busy = state_q != dfas_pkg::ST_IDLE;
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  dfas_ram #(
    .WIDTH(32),
    .DEPTH(RAM_DEPTH),
    .AW   (RAM_AW)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(base + RAM_AW'(pos_q[sidx])),
    .wdata_i(dur),
    .re_i   (re),
    .raddr_i(base_q + RAM_AW'(scan_q)),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= dfas_pkg::ST_IDLE;
      cmd_q      <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        phase_q[i]    <= dfas_pkg::PH_PENDING;
        deadline_q[i] <= '0;
        start_q[i]    <= '0;
      end
      for (int s = 0; s < STAGE_COUNT; s++) begin
        pos_q[s]   <= '0;
        fill_q[s]  <= '0;
        rc_q[s]    <= '0;
        est_q[s]   <= dfas_pkg::EST_RESET;
        worst_q[s] <= dfas_pkg::WORST_RESET;
      end
      for (int i = 0; i < TOP_K; i++) begin
        top_q[i] <= '0;
      end
      done_cnt_q <= '0;
      drop_cnt_q <= '0;
      status_q   <= 1'b0;
      proceed_q  <= 1'b0;
      slot_q     <= '0;
      needed_q   <= '0;
      base_q     <= '0;
      n_q        <= '0;
      scan_q     <= '0;
      rd_vld_q   <= 1'b0;
      res_q      <= '0;
      res_vld_q  <= 1'b0;
    end else begin
      if (res_load) res_vld_q <= 1'b1;
      else if (pop_i && res_vld_q) res_vld_q <= 1'b0;
      case (state_q)
        dfas_pkg::ST_IDLE: begin
          if (take) begin
            cmd_q   <= cmd_i;
            state_q <= dfas_pkg::ST_EXEC;
          end
        end
        dfas_pkg::ST_EXEC: begin
          status_q  <= (cmd_q.op == dfas_pkg::OP_SUBMIT) && !found;
          slot_q    <= slot_d;
          proceed_q <= (cmd_q.op == dfas_pkg::OP_CHECK) && proceed;
          needed_q  <= (cmd_q.op == dfas_pkg::OP_CHECK) ? needed : '0;
          state_q   <= (cpl_ok && trig) ? dfas_pkg::ST_SCAN : dfas_pkg::ST_DONE;
          case (cmd_q.op)
            dfas_pkg::OP_SUBMIT: begin
              if (found) begin
                phase_q[found_idx]    <= dfas_pkg::PH_PENDING;
                start_q[found_idx]    <= '0;
                deadline_q[found_idx] <= deadline_new;
              end
            end
            dfas_pkg::OP_CHECK: begin
            end
            dfas_pkg::OP_START: begin
              if (cmd_q.fid_ok) begin
                phase_q[fidx] <= dfas_pkg::PH_PROCESSING;
                start_q[fidx] <= cmd_q.item.now_us;
              end
            end
            default: begin
              if (cpl_ok) begin
                pos_q[sidx]  <= pos_next;
                fill_q[sidx] <= fill_new;
                if (!fill_sat) rc_q[sidx] <= rc_next;
                if (!cmd_q.item.success) begin
                  phase_q[fidx] <= dfas_pkg::PH_FAILED;
                  drop_cnt_q    <= drop_cnt_q + 1'b1;
                end else if (int'(cmd_q.item.stage) == STAGE_COUNT - 1) begin
                  phase_q[fidx] <= dfas_pkg::PH_COMPLETED;
                  done_cnt_q    <= done_cnt_q + 1'b1;
                end
                if (trig) begin
                  base_q   <= base;
                  n_q      <= fill_new;
                  scan_q   <= '0;
                  rd_vld_q <= 1'b0;
                  for (int i = 0; i < TOP_K; i++) begin
                    top_q[i] <= '0;
                  end
                end
              end
            end
          endcase
        end
        dfas_pkg::ST_SCAN: begin
          rd_vld_q <= re;
          if (re) scan_q <= scan_q + 1'b1;
          if (rd_vld_q) top_q <= top_new;
          if (!re && !rd_vld_q) state_q <= dfas_pkg::ST_UPD;
        end
        dfas_pkg::ST_UPD: begin
          est_q[sidx] <= top_q[rank];
          if (top_q[0] > worst_q[sidx]) worst_q[sidx] <= top_q[0];
          state_q <= dfas_pkg::ST_DONE;
        end
        dfas_pkg::ST_DONE: begin
          if (res_load) begin
            res_q.status          <= status_q;
            res_q.slot            <= slot_q;
            res_q.proceed         <= proceed_q;
            res_q.needed_us       <= needed_q;
            res_q.stage_estimate  <= cmd_q.st_ok ? est_q[sidx] : '0;
            res_q.stage_worst     <= cmd_q.st_ok ? worst_q[sidx] : '0;
            res_q.processed_count <= done_cnt_q;
            res_q.dropped_count   <= drop_cnt_q;
            state_q               <= dfas_pkg::ST_IDLE;
          end
        end
        default: begin
          state_q <= dfas_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule
